FILE: design/fatcw_pkg.sv
// Package for the FAT32 cluster chain walker: constants, widths, codes and types.
// Used by fat_cluster_chain_walker_core. It has no dependencies.
package fatcw_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned CHAIN_LIMIT   = 63;

  localparam int unsigned TBL_AW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W    = $clog2(CHAIN_LIMIT + 1);
  localparam int unsigned SB_W     = 13;
  localparam int unsigned DS_W     = 41;
  localparam int unsigned SEC_W    = 42;
  localparam int unsigned MUL_W    = SEC_W + SB_W;
  localparam int unsigned OFF_W    = 48;
  localparam int unsigned BCNT_W   = 20;
  localparam int unsigned CFG_IX_W = 3;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [31:0]       FIRST_CLUSTER = 32'h0000_0002;
  localparam logic [31:0]       END_MARK      = 32'h0FFF_FFF8;
  localparam logic [31:0]       CLUSTER_MASK  = 32'h0FFF_FFFF;
  localparam logic [TBL_AW-1:0] CLUSTER_BIAS  = TBL_AW'(2);
  localparam logic [BCNT_W-1:0] COUNT_MAX     = '1;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_RESERVED_SECTORS = 3'd0,
    CFG_SECTOR_BYTES     = 3'd1,
    CFG_CLUSTER_SECTORS  = 3'd2,
    CFG_TABLE_COPIES     = 3'd3,
    CFG_TABLE_SECTORS    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_WALK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_END   = 2'd1,
    STAT_LIMIT = 2'd2,
    STAT_RANGE = 2'd3
  } stat_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DS,
    ST_BPC,
    ST_SAT,
    ST_CHECK,
    ST_SEC,
    ST_OFF,
    ST_CNT,
    ST_EMIT
  } walk_state_e;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [BCNT_W-1:0] count;
    stat_e             status;
    logic              last;
  } result_t;

endpackage

FILE: design/fat_cluster_chain_walker_core.sv
// FAT32 cluster chain walker: allocation table memory, shared multiplier and walk sequencer.
// Depends on fatcw_pkg.
//
// A write transaction stores one allocation table entry. A walk transaction runs setup steps
// (data start sector, then bytes per cluster), then check, sector, offset, count and emit steps
// per cluster and an emit step for the closing status record; each emit step waits while the
// output side stalls. The walk is paced by the single 42x13 multiplier, used twice per cluster
// (sector number, then byte offset) with a register after each product, and by the table
// memory whose registered read gives the next cluster. The input stalls while a walk runs; a
// finished record sits in the output register, so a new transaction is accepted while the last
// status record still waits to be taken.
// The table is not cleared at reset: an entry must be written before a walk reads it.
module fat_cluster_chain_walker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [11:0]                    entry_index_i,
  input  logic [31:0]                    entry_value_i,
  input  logic [31:0]                    start_cluster_i,
  input  logic [31:0]                    file_bytes_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [47:0]                    byte_offset_o,
  output logic [19:0]                    byte_count_o,
  output logic [1:0]                     status_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [fatcw_pkg::CFG_IX_W-1:0] cfg_index_i,
  input  logic [fatcw_pkg::CFG_DW-1:0]   cfg_data_i
);
  import fatcw_pkg::*;

  walk_state_e       state_q, state_d;
  logic [15:0]       reserved_q;
  logic [SB_W-1:0]   sector_bytes_q;
  logic [7:0]        cluster_sectors_q;
  logic [7:0]        copies_q;
  logic [31:0]       table_sectors_q;

  logic [31:0]       cur_q, cur_d;
  logic [31:0]       rem_q, rem_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [DS_W-1:0]   ds_q, ds_d;
  logic [BCNT_W-1:0] bpc_q, bpc_d;
  logic [SEC_W-1:0]  sec_q, sec_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [SEC_W-1:0]  mul_a;
  logic [SB_W-1:0]   mul_b;
  logic [MUL_W-1:0]  mul_q;

  logic [31:0]       tbl [TABLE_ENTRIES];
  logic [31:0]       rd_q;
  logic              tbl_we;
  logic              in_acc;
  logic              out_free;
  logic [BCNT_W-1:0] cnt;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign tbl_we        = in_acc && (op_e'(operation_i) == OP_WRITE)
                         && (32'(entry_index_i) < 32'(TABLE_ENTRIES));
  assign out_free      = !out_valid_q || !out_stall_i;
  assign cnt           = (rem_q < 32'(bpc_q)) ? rem_q[BCNT_W-1:0] : bpc_q;

  assign out_valid_o   = out_valid_q;
  assign byte_offset_o = out_q.offset;
  assign byte_count_o  = out_q.count;
  assign status_o      = out_q.status;
  assign last_o        = out_q.last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q        <= 16'd32;
      sector_bytes_q    <= SB_W'(512);
      cluster_sectors_q <= 8'd8;
      copies_q          <= 8'd2;
      table_sectors_q   <= 32'd1024;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_RESERVED_SECTORS: reserved_q        <= cfg_data_i[15:0];
        CFG_SECTOR_BYTES:     sector_bytes_q    <= cfg_data_i[SB_W-1:0];
        CFG_CLUSTER_SECTORS:  cluster_sectors_q <= cfg_data_i[7:0];
        CFG_TABLE_COPIES:     copies_q          <= cfg_data_i[7:0];
        CFG_TABLE_SECTORS:    table_sectors_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // allocation table
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl[TBL_AW'(entry_index_i)] <= entry_value_i;
    end
    rd_q <= tbl[cur_q[TBL_AW-1:0]];
  end

  // shared multiplier
  always_comb begin
    mul_a = SEC_W'(cur_q[TBL_AW-1:0] - CLUSTER_BIAS);
    mul_b = SB_W'(cluster_sectors_q);
    case (state_q)
      ST_DS: begin
        mul_a = SEC_W'(table_sectors_q);
        mul_b = SB_W'(copies_q);
      end
      ST_BPC: begin
        mul_a = SEC_W'(sector_bytes_q);
        mul_b = SB_W'(cluster_sectors_q);
      end
      ST_OFF: begin
        mul_a = sec_q;
        mul_b = sector_bytes_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    n_d         = n_q;
    ds_d        = ds_q;
    bpc_d       = bpc_q;
    sec_d       = sec_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_e'(operation_i) == OP_WALK)) begin
          cur_d   = start_cluster_i;
          rem_d   = file_bytes_i;
          n_d     = '0;
          state_d = ST_DS;
        end
      end
      ST_DS: state_d = ST_BPC;
      ST_BPC: begin
        ds_d    = mul_q[DS_W-1:0] + DS_W'(reserved_q);
        state_d = ST_SAT;
      end
      ST_SAT: begin
        bpc_d   = (mul_q > MUL_W'(COUNT_MAX)) ? COUNT_MAX : mul_q[BCNT_W-1:0];
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if ((cur_q < FIRST_CLUSTER) || (cur_q >= END_MARK)) begin
          res_d   = '{offset: '0, count: '0, status: STAT_END, last: 1'b1};
          state_d = ST_EMIT;
        end else if (cur_q >= 32'(TABLE_ENTRIES)) begin
          res_d   = '{offset: '0, count: '0, status: STAT_RANGE, last: 1'b1};
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SEC;
        end
      end
      ST_SEC: begin
        sec_d   = SEC_W'(mul_q[19:0]) + SEC_W'(ds_q);
        state_d = ST_OFF;
      end
      ST_OFF: state_d = ST_CNT;
      ST_CNT: begin
        res_d   = '{offset: mul_q[OFF_W-1:0], count: cnt, status: STAT_OK, last: 1'b0};
        rem_d   = rem_q - 32'(cnt);
        n_d     = n_q + 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          if (res_q.last) begin
            state_d = ST_IDLE;
          end else if (rem_q == '0) begin
            res_d = '{offset: '0, count: '0, status: STAT_OK, last: 1'b1};
          end else if (n_q >= CNT_W'(CHAIN_LIMIT)) begin
            res_d = '{offset: '0, count: '0, status: STAT_LIMIT, last: 1'b1};
          end else begin
            cur_d   = rd_q & CLUSTER_MASK;
            state_d = ST_CHECK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rem_q <= rem_d;
    n_q   <= n_d;
    ds_q  <= ds_d;
    bpc_q <= bpc_d;
    sec_q <= sec_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  a_cnt_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CNT) |=> (state_q == ST_EMIT) && !res_q.last)
    else $error("data record not staged after count step");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (byte_count_o == '0) && (byte_offset_o == '0))
    else $error("status record carries data");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (status_o == STAT_OK))
    else $error("data record with nonzero status");

  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> (n_q < CNT_W'(CHAIN_LIMIT)))
    else $error("walk continued past chain limit");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && !res_q.last && rem_q == '0)
      |=> (state_q == ST_EMIT) && res_q.last && (res_q.status == STAT_OK))
    else $error("used-up file did not close with status record");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for fat_cluster_chain_walker_core: loads cluster chains into the allocation table,
// walks them under several register settings and checks each record against a chain predictor.
// Depends on fatcw_pkg and the core RTL.

module tb;
  import fatcw_pkg::*;

  class chain_scoreboard;
    logic [31:0] fat_word [TABLE_ENTRIES];
    bit          fat_valid [TABLE_ENTRIES];
    logic [15:0] rsv_sectors;
    logic [12:0] sec_bytes;
    logic [7:0]  clu_sectors;
    logic [7:0]  fat_copies;
    logic [31:0] fat_sectors;
    result_t     record_q [$];
    int          errors;
    int          writes;
    int          walks;
    int          records;
    int          ending_seen [4];

    function new();
      rsv_sectors = 16'd32;
      sec_bytes   = 13'd512;
      clu_sectors = 8'd8;
      fat_copies  = 8'd2;
      fat_sectors = 32'd1024;
      errors  = 0;
      writes  = 0;
      walks   = 0;
      records = 0;
      foreach (ending_seen[i]) ending_seen[i] = 0;
      foreach (fat_valid[i]) begin
        fat_valid[i] = 1'b0;
        fat_word[i]  = '0;
      end
    endfunction

    function void set_reg(cfg_reg_e ix, logic [31:0] v);
      case (ix)
        CFG_RESERVED_SECTORS: rsv_sectors = v[15:0];
        CFG_SECTOR_BYTES:     sec_bytes   = v[12:0];
        CFG_CLUSTER_SECTORS:  clu_sectors = v[7:0];
        CFG_TABLE_COPIES:     fat_copies  = v[7:0];
        CFG_TABLE_SECTORS:    fat_sectors = v;
        default: ;
      endcase
    endfunction

    function bit [63:0] cluster_bytes();
      bit [63:0] b;
      b = 64'(clu_sectors) * 64'(sec_bytes);
      return (b > 64'(COUNT_MAX)) ? 64'(COUNT_MAX) : b;
    endfunction

    function void push_record(bit [63:0] off, logic [31:0] cnt, stat_e st, logic lst);
      result_t r;
      r.offset = off[OFF_W-1:0];
      r.count  = cnt[BCNT_W-1:0];
      r.status = st;
      r.last   = lst;
      record_q.push_back(r);
      if (lst) ending_seen[int'(st)]++;
    endfunction

    // With emit set, queues the records of a walk. Without it, returns the first table
    // entry the walk would read before it was ever written, or -1.
    function int follow_chain(logic [31:0] start, logic [31:0] bytes, bit emit);
      bit [63:0]   data_start;
      bit [63:0]   bpc;
      bit [63:0]   sector;
      logic [31:0] cur;
      logic [31:0] remaining;
      logic [31:0] cnt;
      int          n;
      int          miss;
      bit          done;
      data_start = 64'(rsv_sectors) + 64'(fat_copies) * 64'(fat_sectors);
      bpc        = cluster_bytes();
      cur        = start;
      remaining  = bytes;
      n          = 0;
      miss       = -1;
      done       = 1'b0;
      while (!done) begin
        if (cur < FIRST_CLUSTER || cur >= END_MARK) begin
          if (emit) push_record(64'd0, 32'd0, STAT_END, 1'b1);
          done = 1'b1;
        end else if (cur >= TABLE_ENTRIES) begin
          if (emit) push_record(64'd0, 32'd0, STAT_RANGE, 1'b1);
          done = 1'b1;
        end else begin
          sector = 64'(cur - 32'(CLUSTER_BIAS)) * 64'(clu_sectors) + data_start;
          cnt = (64'(remaining) < bpc) ? remaining : bpc[31:0];
          if (emit) push_record(sector * 64'(sec_bytes), cnt, STAT_OK, 1'b0);
          n++;
          remaining -= cnt;
          if (remaining == 0) begin
            if (emit) push_record(64'd0, 32'd0, STAT_OK, 1'b1);
            done = 1'b1;
          end else if (n >= CHAIN_LIMIT) begin
            if (emit) push_record(64'd0, 32'd0, STAT_LIMIT, 1'b1);
            done = 1'b1;
          end else if (!emit && !fat_valid[cur[TBL_AW-1:0]]) begin
            miss = int'(cur);
            done = 1'b1;
          end else begin
            cur = fat_word[cur[TBL_AW-1:0]] & CLUSTER_MASK;
          end
        end
      end
      return miss;
    endfunction

    function void note_input(op_e op, logic [11:0] ix, logic [31:0] val,
                             logic [31:0] start, logic [31:0] bytes);
      if (op == OP_WRITE) begin
        fat_word[ix]  = val;
        fat_valid[ix] = 1'b1;
        writes++;
      end else begin
        walks++;
        void'(follow_chain(start, bytes, 1'b1));
      end
    endfunction

    function void mismatch(string field, logic [63:0] exp, logic [63:0] act);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp, act);
    endfunction

    function void check_result(logic [47:0] off, logic [19:0] cnt, logic [1:0] st, logic lst);
      result_t e;
      records++;
      if (record_q.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected record, offset %0h count %0h status %0d last %0b",
                   $time, off, cnt, st, lst);
        return;
      end
      e = record_q.pop_front();
      if (e.offset !== off) mismatch("byte_offset", 64'(e.offset), 64'(off));
      if (e.count !== cnt) mismatch("byte_count", 64'(e.count), 64'(cnt));
      if (e.status !== st) mismatch("status", 64'(e.status), 64'(st));
      if (e.last !== lst) mismatch("last", 64'(e.last), 64'(lst));
    endfunction

    function int pending();
      return record_q.size();
    endfunction
  endclass

  localparam int IDLE_LIMIT = 4000;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  op_e                 in_op      = OP_WRITE;
  logic [11:0]         in_index   = '0;
  logic [31:0]         in_value   = '0;
  logic [31:0]         in_start   = '0;
  logic [31:0]         in_bytes   = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [47:0]         out_offset;
  logic [19:0]         out_count;
  logic [1:0]          out_status;
  logic                out_last;
  logic                cfg_we     = 1'b0;
  cfg_reg_e            cfg_index  = CFG_RESERVED_SECTORS;
  logic [CFG_DW-1:0]   cfg_data   = '0;

  chain_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  int sent_items    = 0;
  int cfg_sets      = 0;

  fat_cluster_chain_walker_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (in_op),
    .entry_index_i  (in_index),
    .entry_value_i  (in_value),
    .start_cluster_i(in_start),
    .file_bytes_i   (in_bytes),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .byte_offset_o  (out_offset),
    .byte_count_o   (out_count),
    .status_o       (out_status),
    .last_o         (out_last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // record sink: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_offset, out_count, out_status, out_last);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d records outstanding",
               $time, IDLE_LIMIT, sb.pending());
      $display("tb failed");
      $finish;
    end
  end

  task automatic send(op_e op, logic [11:0] ix, logic [31:0] val,
                      logic [31:0] start, logic [31:0] bytes);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_index <= ix;
    in_value <= val;
    in_start <= start;
    in_bytes <= bytes;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, ix, val, start, bytes);
    sent_items++;
  endtask

  task automatic store_entry(logic [11:0] ix, logic [31:0] val);
    send(OP_WRITE, ix, val, $urandom, $urandom);
  endtask

  // chain terminator or random link; top nibble is reserved and randomized
  function automatic logic [31:0] filler_word();
    case ($urandom_range(3))
      0: return {4'($urandom), END_MARK[27:0] | 28'($urandom_range(7))};
      1: return {4'($urandom), 28'($urandom_range(1))};
      2: return {4'($urandom), 28'($urandom_range(TABLE_ENTRIES - 1, 2))};
      default: return $urandom;
    endcase
  endfunction

  // fills any entry the walk would read unwritten, then issues the walk
  task automatic walk_file(logic [31:0] start, logic [31:0] bytes);
    int miss;
    miss = sb.follow_chain(start, bytes, 1'b0);
    while (miss >= 0) begin
      store_entry(12'(miss), filler_word());
      miss = sb.follow_chain(start, bytes, 1'b0);
    end
    send(OP_WALK, 12'($urandom), $urandom, start, bytes);
  endtask

  task automatic chain_walk();
    logic [11:0] link [$];
    int          len;
    int          pick;
    logic [31:0] tail;
    logic [31:0] bytes;
    bit [63:0]   bpc;
    pick = $urandom_range(99);
    len  = (pick < 70) ? $urandom_range(6, 1) :
           (pick < 90) ? $urandom_range(20, 7) : $urandom_range(70, 55);
    repeat (len) link.push_back(12'($urandom_range(TABLE_ENTRIES - 1, 2)));
    for (int i = 0; i + 1 < len; i++)
      store_entry(link[i], {4'($urandom), 16'd0, link[i + 1]});
    if ($urandom_range(3) == 0)
      tail = {4'($urandom), 16'd0, link[$urandom_range(len - 1)]};
    else
      tail = filler_word();
    store_entry(link[len - 1], tail);
    bpc = sb.cluster_bytes();
    case ($urandom_range(5))
      0: bytes = 32'd0;
      1: bytes = 32'(bpc) * $urandom_range(len, 1);
      2: bytes = $urandom_range(32'(bpc) * len);
      3: bytes = 32'hFFFF_FFFF;
      4: bytes = $urandom_range(3, 1);
      default: bytes = $urandom;
    endcase
    walk_file({20'd0, link[0]}, bytes);
  endtask

  task automatic random_items(int count);
    int stop;
    stop = sent_items + count;
    while (sent_items < stop) begin
      case ($urandom_range(9))
        0, 1: store_entry(12'($urandom), $urandom);
        2: walk_file($urandom, $urandom);
        3: walk_file($urandom_range(TABLE_ENTRIES - 1), $urandom);
        default: chain_walk();
      endcase
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // a trailing table write may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic load_regs(logic [15:0] rsv, logic [12:0] sbytes, logic [7:0] csec,
                           logic [7:0] copies, logic [31:0] tsec);
    cfg_reg_e    regs [5];
    logic [31:0] vals [5];
    regs = '{CFG_RESERVED_SECTORS, CFG_SECTOR_BYTES, CFG_CLUSTER_SECTORS,
             CFG_TABLE_COPIES, CFG_TABLE_SECTORS};
    vals = '{32'(rsv), 32'(sbytes), 32'(csec), 32'(copies), tsec};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_sets++;
  endtask

  initial begin
    send_idle_pct = 14;
    recv_idle_pct = 46;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, 4096-byte clusters
    store_entry(12'd2, 32'd3);
    store_entry(12'd3, 32'h0FFF_FFFF);
    store_entry(12'd4095, 32'hFFFF_FFFF);
    store_entry(12'd0, 32'd0);
    store_entry(12'd5, 32'h0000_1000);
    store_entry(12'd6, 32'd6);
    store_entry(12'd7, 32'hF000_0007);
    walk_file(32'd2, 32'd8192);
    walk_file(32'd2, 32'd0);
    walk_file(32'd2, 32'd100000);
    walk_file(32'd0, 32'd1);
    walk_file(32'd1, 32'd4096);
    walk_file(32'h0FFF_FFF8, 32'd1);
    walk_file(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    walk_file(32'd4096, 32'd1);
    walk_file(32'h0FFF_FFF7, 32'd1);
    walk_file(32'd5, 32'hFFFF_FFFF);
    walk_file(32'd6, 32'hFFFF_FFFF);
    walk_file(32'd7, 32'd100000);
    walk_file(32'd4095, 32'd1);
    walk_file(32'd4095, 32'hFFFF_FFFF);
    drain();

    load_regs(16'd0, 13'd512, 8'd1, 8'd1, 32'd0);
    random_items(75);
    drain();

    load_regs(16'hFFFF, 13'd4096, 8'd128, 8'd255, 32'hFFFF_FFFF);
    hold_req = 300;
    random_items(75);
    drain();

    send_idle_pct = 46;
    recv_idle_pct = 14;
    // cluster size beyond the count field
    load_regs(16'($urandom), 13'd8191, 8'd255, 8'($urandom), $urandom);
    random_items(40);
    drain();
    random_items(35);
    drain();

    // zero-size clusters
    load_regs(16'($urandom), 13'($urandom), 8'd0, 8'($urandom), $urandom);
    random_items(75);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_regs(16'($urandom), 13'd0, 8'($urandom), 8'($urandom), $urandom);
    random_items(75);
    drain();

    load_regs(16'($urandom), 13'($urandom), 8'($urandom), 8'($urandom), $urandom);
    random_items(75);
    drain();
    repeat (40) @(posedge clk);

    $display("covered %0d table writes and %0d walks over %0d register settings, %0d records",
             sb.writes, sb.walks, cfg_sets + 1, sb.records);
    $display("walk endings: size used up %0d, chain end %0d, limit %0d, outside table %0d",
             sb.ending_seen[0], sb.ending_seen[1], sb.ending_seen[2], sb.ending_seen[3]);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule

FILE: files.f
design/fatcw_pkg.sv
design/fat_cluster_chain_walker_core.sv
test/tb.sv
